// File: rtl/bpmm_pkg.sv
// Shared widths, constants and types of the balancing PID motor mixer.
// No dependencies; every other file of the block refers to this package.

package bpmm_pkg;

    localparam int DATA_W    = 32;          // Q16.16 data words
    localparam int MAG_W     = 31;          // motor magnitude
    localparam int SCALE_W   = 19;          // motor compensation factor
    localparam int INTEG_W   = 48;          // error integral
    localparam int OPND_W    = 33;          // shared multiplier operand
    localparam int PROD_W    = 2 * OPND_W;  // shared multiplier product
    localparam int KI_W      = 39;          // Ki * 100
    localparam int NUM_W     = 63;          // derivative numerator magnitude
    localparam int DEN_W     = 39;          // 100 * dt
    localparam int WIDE_W    = 72;          // saturation input width
    localparam int ACC_W     = 88;          // partial product accumulator
    localparam int CFG_IDX_W = 3;

    localparam logic [DATA_W-1:0]  SPEED_GAIN = 32'd17179869;    // 0.004 in Q0.32
    localparam logic [DATA_W-1:0]  SPEED_LEAK = 32'd4290672329;  // 0.999 in Q0.32
    localparam logic [6:0]         HUNDRED    = 7'd100;
    localparam logic [SCALE_W-1:0] SCALE_ONE  = 19'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P      = 3'd0,
        REG_GAIN_I      = 3'd1,
        REG_GAIN_D      = 3'd2,
        REG_LEFT_SCALE  = 3'd3,
        REG_RIGHT_SCALE = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic busy;     // division in progress
        logic rem_nz;   // remainder of the last division is nonzero
    } div_status_t;

endpackage

// File: rtl/bpmm_if.sv
// Valid/ready channel interfaces of the balancing PID motor mixer.
// Depends on bpmm_pkg for field widths.

interface bpmm_upd_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 kind;
    logic signed [bpmm_pkg::DATA_W-1:0]   pitch_angle;
    logic signed [bpmm_pkg::DATA_W-1:0]   rest_angle;
    logic signed [bpmm_pkg::DATA_W-1:0]   turn_amount;
    logic        [bpmm_pkg::DATA_W-1:0]   time_step;

    modport source (
        output valid, kind, pitch_angle, rest_angle, turn_amount, time_step,
        input  ready
    );
    modport sink (
        input  valid, kind, pitch_angle, rest_angle, turn_amount, time_step,
        output ready
    );
endinterface

interface bpmm_res_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 left_backward;
    logic        [bpmm_pkg::MAG_W-1:0]    left_magnitude;
    logic                                 right_backward;
    logic        [bpmm_pkg::MAG_W-1:0]    right_magnitude;
    logic signed [bpmm_pkg::DATA_W-1:0]   control_value;

    modport source (
        output valid, left_backward, left_magnitude, right_backward, right_magnitude,
               control_value,
        input  ready
    );
    modport sink (
        input  valid, left_backward, left_magnitude, right_backward, right_magnitude,
               control_value,
        output ready
    );
endinterface

// File: rtl/bpmm_mul.sv
// Shared signed multiplier with a registered product.
// Depends on bpmm_pkg for operand and product widths.

module bpmm_mul (
    input  logic                                 clk,
    input  logic signed [bpmm_pkg::OPND_W-1:0]   a,
    input  logic signed [bpmm_pkg::OPND_W-1:0]   b,
    output logic signed [bpmm_pkg::PROD_W-1:0]   p
);

    logic signed [bpmm_pkg::PROD_W-1:0] p_reg;

    // one product per cycle, ready in the next
    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

// File: rtl/bpmm_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on bpmm_pkg for widths and the status struct.

module bpmm_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [bpmm_pkg::NUM_W-1:0]        num,
    input  logic [bpmm_pkg::DEN_W-1:0]        den,
    output logic [bpmm_pkg::NUM_W-1:0]        quo,
    output bpmm_pkg::div_status_t             status
);

    localparam int NUM_W = bpmm_pkg::NUM_W;
    localparam int DEN_W = bpmm_pkg::DEN_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = !diff[DEN_W];

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift one numerator bit in, subtract when the divisor fits
            quo_next = {quo_reg[NUM_W-2:0], fits};
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quo           = quo_reg;
    assign status.busy   = busy_reg;
    assign status.rem_nz = (rem_reg != '0);

endmodule

// File: rtl/balance_pid_motor_mixer.sv
// Top level of the balancing PID motor mixer: sequencer, datapath registers,
// configuration registers. Depends on bpmm_pkg, bpmm_if, bpmm_mul, bpmm_div.
//
//   channel   direction   form                      transaction
//   upd       in          bpmm_upd_if.sink          one update or reset item
//   res       out         bpmm_res_if.source        one motor drive result
//   cfg_*     in          write enable/index/data   one register write
//
// From acceptance of an update to the next acceptance, the 63-step restoring
// divider for the derivative term dominates; the shared 33x33 multiplier
// runs the other products under it. A reset item goes from S_IDLE
// straight to S_DONE. upd.ready is high only while the sequencer
// idles; a finished result waits in the output register, so the next item
// may be accepted before res takes it. A result that finds the output
// register still full holds the sequencer until res.ready.
// Reset (rst_n, asynchronous, active low) clears the controller state and
// loads the register reset values.

module balance_pid_motor_mixer (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [bpmm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bpmm_pkg::DATA_W-1:0]        cfg_data,
    bpmm_upd_if.sink                           upd,
    bpmm_res_if.source                         res
);

    localparam int DATA_W  = bpmm_pkg::DATA_W;
    localparam int MAG_W   = bpmm_pkg::MAG_W;
    localparam int SCALE_W = bpmm_pkg::SCALE_W;
    localparam int INTEG_W = bpmm_pkg::INTEG_W;
    localparam int OPND_W  = bpmm_pkg::OPND_W;
    localparam int PROD_W  = bpmm_pkg::PROD_W;
    localparam int KI_W    = bpmm_pkg::KI_W;
    localparam int NUM_W   = bpmm_pkg::NUM_W;
    localparam int DEN_W   = bpmm_pkg::DEN_W;
    localparam int WIDE_W  = bpmm_pkg::WIDE_W;
    localparam int ACC_W   = bpmm_pkg::ACC_W;
    localparam int QM_W    = NUM_W + 1;

    // ------------------------------------------------------------------
    // Sequencer states. Each M_* state presents operands to the shared
    // multiplier; the matching U_* state consumes the registered product.
    // ------------------------------------------------------------------
    typedef enum logic [4:0] {
        S_IDLE,
        S_M_DEN, S_U_DEN,       // 100 * dt
        S_M_KD,  S_U_KD,        // Kd * (e - previous error), start divider
        S_M_EDT, S_U_EDT,       // e * dt, integral update
        S_M_KP,  S_U_KP,        // P term
        S_M_KI,  S_U_KI,        // Ki * 100
        S_M_I0,  S_U_I0,        // four partial products of Ki100 * integral
        S_M_I1,  S_U_I1,
        S_M_I2,  S_U_I2,
        S_M_I3,  S_U_I3,
        S_FIN_I,                // I term from the accumulator
        S_W_DIV,                // wait for the D term quotient
        S_SUM,                  // pid = P + I + D
        S_M_C1,  S_U_C1,        // speed estimate gain
        S_M_C2,  S_U_C2,        // speed estimate leak
        S_CTL,                  // control value
        S_M_L,   S_U_L,         // left side
        S_M_R,   S_U_R,         // right side
        S_DONE                  // hand the result to the output register
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic signed [DATA_W-1:0]  gain_p_reg, gain_i_reg, gain_d_reg;
    logic        [SCALE_W-1:0] left_scale_reg, right_scale_reg;

    // controller state
    logic signed [DATA_W-1:0]  prev_err_reg, prev_err_next;
    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic signed [DATA_W-1:0]  speed_reg, speed_next;

    // working registers of one update
    logic signed [DATA_W-1:0]  err_reg, err_next;
    logic signed [DATA_W-1:0]  turn_reg, turn_next;
    logic        [DATA_W-1:0]  dt_reg, dt_next;
    logic signed [KI_W-1:0]    ki100_reg, ki100_next;
    logic        [DEN_W-1:0]   den_reg, den_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic                      d_neg_reg, d_neg_next;
    logic signed [DATA_W-1:0]  p_reg, p_next;
    logic signed [DATA_W-1:0]  iv_reg, iv_next;
    logic signed [DATA_W-1:0]  d_reg, d_next;
    logic signed [DATA_W-1:0]  pid_reg, pid_next;
    logic signed [DATA_W-1:0]  ctl_reg, ctl_next;
    logic                      lb_reg, lb_next, rb_reg, rb_next;
    logic        [MAG_W-1:0]   lm_reg, lm_next, rm_reg, rm_next;

    // output register
    logic                      res_valid_reg, res_valid_next;
    logic                      out_lb_reg, out_lb_next, out_rb_reg, out_rb_next;
    logic        [MAG_W-1:0]   out_lm_reg, out_lm_next, out_rm_reg, out_rm_next;
    logic signed [DATA_W-1:0]  out_ctl_reg, out_ctl_next;

    // shared units
    logic signed [OPND_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic                      div_start;
    logic        [NUM_W-1:0]   div_num;
    logic        [NUM_W-1:0]   div_quo;
    bpmm_pkg::div_status_t     div_status;

    // datapath helpers
    logic                      upd_fire;
    logic        [DATA_W-1:0]  dt_eff;
    logic signed [DATA_W-1:0]  prod_sh16_sat;
    logic signed [DATA_W-1:0]  prod_sh32_sat;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [PROD_W-1:0]  prod_abs;
    logic        [QM_W-1:0]    quo_mag;
    logic signed [WIDE_W-1:0]  d_wide;

    // ------------------------------------------------------------------
    // Saturation helpers
    // ------------------------------------------------------------------
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic [WIDE_W-DATA_W:0] top;
        top = v[WIDE_W-1:DATA_W-1];
        if (top == '0 || top == '1)
        begin
            return v[DATA_W-1:0];
        end
        else if (v[WIDE_W-1])
        begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [INTEG_W-1:0] sat48(input logic signed [INTEG_W:0] v);
        if (v[INTEG_W] == v[INTEG_W-1])
        begin
            return v[INTEG_W-1:0];
        end
        else if (v[INTEG_W])
        begin
            return {1'b1, {(INTEG_W-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(INTEG_W-1){1'b1}}};
        end
    endfunction

    // magnitude of one side, clipped so the most negative value still fits
    function automatic logic [MAG_W-1:0] side_mag(input logic signed [DATA_W-1:0] v);
        logic [DATA_W-1:0] neg_v;
        neg_v = -v;
        if (!v[DATA_W-1])
        begin
            return v[MAG_W-1:0];
        end
        else if (neg_v[DATA_W-1])
        begin
            return '1;
        end
        else
        begin
            return neg_v[MAG_W-1:0];
        end
    endfunction

    // ------------------------------------------------------------------
    // Shared units
    // ------------------------------------------------------------------
    bpmm_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    bpmm_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (den_reg),
        .quo    (div_quo),
        .status (div_status)
    );

    assign upd_fire = upd.valid && upd.ready;
    assign upd.ready = (state_reg == S_IDLE);

    // a zero time step divides by one tick instead
    assign dt_eff = (dt_reg == '0) ? DATA_W'(1) : dt_reg;

    // floor shifts of the product, saturated to a data word
    assign prod_sh16_sat = sat32(WIDE_W'($signed(mul_p[PROD_W-1:16])));
    assign prod_sh32_sat = sat32(WIDE_W'($signed(mul_p[PROD_W-1:32])));

    // e*dt always fits 64 bits, so its floor shift is exact in 48
    assign integ_sum = (INTEG_W + 1)'(integ_reg)
                     + (INTEG_W + 1)'($signed(mul_p[INTEG_W+15:16]));

    // Kd * error change: magnitude to the divider, sign kept aside
    assign prod_abs  = mul_p[PROD_W-1] ? -mul_p : mul_p;
    assign div_num   = prod_abs[NUM_W-1:0];
    assign div_start = (state_reg == S_U_KD);

    // floor division of a negative numerator rounds the magnitude up
    assign quo_mag = QM_W'(div_quo) + QM_W'(d_neg_reg && div_status.rem_nz);
    assign d_wide  = d_neg_reg ? -(WIDE_W'(quo_mag)) : WIDE_W'(div_quo);

    // ------------------------------------------------------------------
    // Multiplier operand select
    // ------------------------------------------------------------------
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_M_DEN:
            begin
                mul_a = {1'b0, dt_eff};
                mul_b = OPND_W'(bpmm_pkg::HUNDRED);
            end
            S_M_KD:
            begin
                mul_a = OPND_W'(gain_d_reg);
                mul_b = OPND_W'(err_reg) - OPND_W'(prev_err_reg);
            end
            S_M_EDT:
            begin
                mul_a = OPND_W'(err_reg);
                mul_b = {1'b0, dt_reg};
            end
            S_M_KP:
            begin
                mul_a = OPND_W'(gain_p_reg);
                mul_b = OPND_W'(err_reg);
            end
            S_M_KI:
            begin
                mul_a = OPND_W'(gain_i_reg);
                mul_b = OPND_W'(bpmm_pkg::HUNDRED);
            end
            // Ki100 and the integral split into a low unsigned word and a
            // signed high part; the four products are summed with shifts
            S_M_I0:
            begin
                mul_a = {1'b0, ki100_reg[DATA_W-1:0]};
                mul_b = {1'b0, integ_reg[DATA_W-1:0]};
            end
            S_M_I1:
            begin
                mul_a = {1'b0, ki100_reg[DATA_W-1:0]};
                mul_b = OPND_W'($signed(integ_reg[INTEG_W-1:DATA_W]));
            end
            S_M_I2:
            begin
                mul_a = OPND_W'($signed(ki100_reg[KI_W-1:DATA_W]));
                mul_b = {1'b0, integ_reg[DATA_W-1:0]};
            end
            S_M_I3:
            begin
                mul_a = OPND_W'($signed(ki100_reg[KI_W-1:DATA_W]));
                mul_b = OPND_W'($signed(integ_reg[INTEG_W-1:DATA_W]));
            end
            S_M_C1:
            begin
                mul_a = OPND_W'(pid_reg);
                mul_b = {1'b0, bpmm_pkg::SPEED_GAIN};
            end
            S_M_C2:
            begin
                mul_a = OPND_W'(speed_reg);
                mul_b = {1'b0, bpmm_pkg::SPEED_LEAK};
            end
            S_M_L:
            begin
                mul_a = OPND_W'(ctl_reg) - OPND_W'(turn_reg);
                mul_b = OPND_W'(left_scale_reg);
            end
            S_M_R:
            begin
                mul_a = OPND_W'(ctl_reg) + OPND_W'(turn_reg);
                mul_b = OPND_W'(right_scale_reg);
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer and datapath next values
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        prev_err_next  = prev_err_reg;
        integ_next     = integ_reg;
        speed_next     = speed_reg;
        err_next       = err_reg;
        turn_next      = turn_reg;
        dt_next        = dt_reg;
        ki100_next     = ki100_reg;
        den_next       = den_reg;
        acc_next       = acc_reg;
        d_neg_next     = d_neg_reg;
        p_next         = p_reg;
        iv_next        = iv_reg;
        d_next         = d_reg;
        pid_next       = pid_reg;
        ctl_next       = ctl_reg;
        lb_next        = lb_reg;
        lm_next        = lm_reg;
        rb_next        = rb_reg;
        rm_next        = rm_reg;
        out_lb_next    = out_lb_reg;
        out_lm_next    = out_lm_reg;
        out_rb_next    = out_rb_reg;
        out_rm_next    = out_rm_reg;
        out_ctl_next   = out_ctl_reg;

        // drop the result once res takes it
        res_valid_next = res_valid_reg && !res.ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (upd_fire)
                begin
                    if (upd.kind)
                    begin
                        // reset item: clear state, stop both motors
                        prev_err_next = '0;
                        integ_next    = '0;
                        speed_next    = '0;
                        ctl_next      = '0;
                        lb_next       = 1'b0;
                        lm_next       = '0;
                        rb_next       = 1'b0;
                        rm_next       = '0;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        err_next   = sat32(WIDE_W'(upd.rest_angle) - WIDE_W'(upd.pitch_angle));
                        turn_next  = upd.turn_amount;
                        dt_next    = upd.time_step;
                        state_next = S_M_DEN;
                    end
                end
            end
            S_M_DEN: state_next = S_U_DEN;
            S_U_DEN:
            begin
                den_next   = mul_p[DEN_W-1:0];
                state_next = S_M_KD;
            end
            S_M_KD: state_next = S_U_KD;
            S_U_KD:
            begin
                // divider starts here and runs under the next products
                d_neg_next    = mul_p[PROD_W-1];
                prev_err_next = err_reg;
                state_next    = S_M_EDT;
            end
            S_M_EDT: state_next = S_U_EDT;
            S_U_EDT:
            begin
                integ_next = sat48(integ_sum);
                state_next = S_M_KP;
            end
            S_M_KP: state_next = S_U_KP;
            S_U_KP:
            begin
                p_next     = prod_sh16_sat;
                state_next = S_M_KI;
            end
            S_M_KI: state_next = S_U_KI;
            S_U_KI:
            begin
                ki100_next = mul_p[KI_W-1:0];
                state_next = S_M_I0;
            end
            S_M_I0: state_next = S_U_I0;
            S_U_I0:
            begin
                acc_next   = ACC_W'(mul_p);
                state_next = S_M_I1;
            end
            S_M_I1: state_next = S_U_I1;
            S_U_I1:
            begin
                acc_next   = acc_reg + (ACC_W'(mul_p) <<< DATA_W);
                state_next = S_M_I2;
            end
            S_M_I2: state_next = S_U_I2;
            S_U_I2:
            begin
                acc_next   = acc_reg + (ACC_W'(mul_p) <<< DATA_W);
                state_next = S_M_I3;
            end
            S_M_I3: state_next = S_U_I3;
            S_U_I3:
            begin
                acc_next   = acc_reg + (ACC_W'(mul_p) <<< (2 * DATA_W));
                state_next = S_FIN_I;
            end
            S_FIN_I:
            begin
                iv_next    = sat32(acc_reg[ACC_W-1:16]);
                state_next = S_W_DIV;
            end
            S_W_DIV:
            begin
                if (!div_status.busy)
                begin
                    d_next     = sat32(d_wide);
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                pid_next   = sat32(WIDE_W'(p_reg) + WIDE_W'(iv_reg) + WIDE_W'(d_reg));
                state_next = S_M_C1;
            end
            S_M_C1: state_next = S_U_C1;
            S_U_C1:
            begin
                speed_next = sat32(WIDE_W'(speed_reg) + WIDE_W'($signed(mul_p[PROD_W-1:32])));
                state_next = S_M_C2;
            end
            S_M_C2: state_next = S_U_C2;
            S_U_C2:
            begin
                speed_next = prod_sh32_sat;
                state_next = S_CTL;
            end
            S_CTL:
            begin
                ctl_next   = sat32(WIDE_W'(pid_reg) + WIDE_W'(speed_reg));
                state_next = S_M_L;
            end
            S_M_L: state_next = S_U_L;
            S_U_L:
            begin
                lb_next    = prod_sh16_sat[DATA_W-1];
                lm_next    = side_mag(prod_sh16_sat);
                state_next = S_M_R;
            end
            S_M_R: state_next = S_U_R;
            S_U_R:
            begin
                rb_next    = prod_sh16_sat[DATA_W-1];
                rm_next    = side_mag(prod_sh16_sat);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next = 1'b1;
                    out_lb_next    = lb_reg;
                    out_lm_next    = lm_reg;
                    out_rb_next    = rb_reg;
                    out_rm_next    = rm_reg;
                    out_ctl_next   = ctl_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control, controller state and configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            res_valid_reg   <= 1'b0;
            prev_err_reg    <= '0;
            integ_reg       <= '0;
            speed_reg       <= '0;
            gain_p_reg      <= '0;
            gain_i_reg      <= '0;
            gain_d_reg      <= '0;
            left_scale_reg  <= bpmm_pkg::SCALE_ONE;
            right_scale_reg <= bpmm_pkg::SCALE_ONE;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            prev_err_reg  <= prev_err_next;
            integ_reg     <= integ_next;
            speed_reg     <= speed_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    bpmm_pkg::REG_GAIN_P:      gain_p_reg      <= cfg_data;
                    bpmm_pkg::REG_GAIN_I:      gain_i_reg      <= cfg_data;
                    bpmm_pkg::REG_GAIN_D:      gain_d_reg      <= cfg_data;
                    bpmm_pkg::REG_LEFT_SCALE:  left_scale_reg  <= cfg_data[SCALE_W-1:0];
                    bpmm_pkg::REG_RIGHT_SCALE: right_scale_reg <= cfg_data[SCALE_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Working and output payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        err_reg     <= err_next;
        turn_reg    <= turn_next;
        dt_reg      <= dt_next;
        ki100_reg   <= ki100_next;
        den_reg     <= den_next;
        acc_reg     <= acc_next;
        d_neg_reg   <= d_neg_next;
        p_reg       <= p_next;
        iv_reg      <= iv_next;
        d_reg       <= d_next;
        pid_reg     <= pid_next;
        ctl_reg     <= ctl_next;
        lb_reg      <= lb_next;
        lm_reg      <= lm_next;
        rb_reg      <= rb_next;
        rm_reg      <= rm_next;
        out_lb_reg  <= out_lb_next;
        out_lm_reg  <= out_lm_next;
        out_rb_reg  <= out_rb_next;
        out_rm_reg  <= out_rm_next;
        out_ctl_reg <= out_ctl_next;
    end

    assign res.valid           = res_valid_reg;
    assign res.left_backward   = out_lb_reg;
    assign res.left_magnitude  = out_lm_reg;
    assign res.right_backward  = out_rb_reg;
    assign res.right_magnitude = out_rm_reg;
    assign res.control_value   = out_ctl_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    a_reset_item_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (upd.valid && upd.ready && upd.kind)
        |=> (integ_reg == '0 && speed_reg == '0 && prev_err_reg == '0))
        else $error("reset transaction left controller state uncleared");

    a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_status.busy)
        else $error("divider restarted while busy");

    a_backward_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> ((!res.left_backward || res.left_magnitude != '0)
                    && (!res.right_backward || res.right_magnitude != '0)))
        else $error("backward direction with zero magnitude");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result loaded outside the hand-off state");
`endif

endmodule
